// ----- src/crcfr_pkg.sv -----
// Shared types, constants and CRC helpers for the framed byte receiver.
package crcfr_pkg;

  // Longest body (command id, payload and tail) the block will track
  localparam int BODY_MAX = 127;
  localparam int REM_W    = $clog2(BODY_MAX + 1);

  // Result queue between the parser and the output stage (power of two)
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  START_BYTE_RST  = 8'd165;
  localparam logic [6:0]  MAX_BODY_RST    = 7'd100;
  localparam logic [7:0]  HDR_CRC_INIT_RST = 8'd255;
  localparam logic [7:0]  HDR_CRC_POLY_RST = 8'd140;
  localparam logic [15:0] FRM_CRC_INIT_RST = 16'd65535;
  localparam logic [15:0] FRM_CRC_POLY_RST = 16'd33800;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE   = 3'd0,
    CFG_MAX_BODY_LEN = 3'd1,
    CFG_HDR_CRC_INIT = 3'd2,
    CFG_HDR_CRC_POLY = 3'd3,
    CFG_FRM_CRC_INIT = 3'd4,
    CFG_FRM_CRC_POLY = 3'd5
  } cfg_idx_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_SEQ    = 3'd3,
    PH_HCRC   = 3'd4,
    PH_BODY   = 3'd5
  } phase_t;

  // One result beat
  typedef struct packed {
    logic [7:0] body_byte;
    logic [6:0] body_index;
    logic [6:0] payload_len;
    logic       is_last;
    logic       frame_ok;
  } res_t;

  // Queue write side
  typedef struct packed {
    logic push;
    res_t data;
  } q_wr_t;

  // Queue read side
  typedef struct packed {
    logic empty;
    res_t data;
  } q_rd_t;

  // Reflected CRC8, one byte, no final xor
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC16, one byte, no final xor
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/crcfr_front.sv -----
// Parser front end: configuration registers, header checks and CRC tracking.
module crcfr_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  input  logic                                 cfg_we,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 q_full,
  output crcfr_pkg::q_wr_t                     q_wr
);

  // Configuration
  logic [7:0]  start_byte_r;
  logic [6:0]  max_body_r;
  logic [7:0]  hdr_init_r;
  logic [7:0]  hdr_poly_r;
  logic [15:0] frm_init_r;
  logic [15:0] frm_poly_r;

  // Parser state
  crcfr_pkg::phase_t             phase_r, phase_nxt;
  logic [crcfr_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [6:0]                    pos_r, pos_nxt;
  logic [7:0]                    len_lo_r, len_lo_nxt;
  logic [7:0]                    hcrc_r, hcrc_nxt;
  logic [15:0]                   fcrc_r, fcrc_nxt;
  logic [7:0]                    tail_lo_r, tail_lo_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  hcrc_feed;
  logic [15:0] fcrc_feed;
  logic [16:0] total;
  logic        too_long;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign b         = in_rx_byte;
  assign hcrc_feed = crcfr_pkg::crc8_step(hcrc_r, b, hdr_poly_r);
  assign fcrc_feed = crcfr_pkg::crc16_step(fcrc_r, b, frm_poly_r);
  assign total     = {1'b0, b, len_lo_r} + 17'd4;
  assign too_long  = (total > {10'd0, max_body_r}) || (total > 17'(crcfr_pkg::BODY_MAX));

  // Next state and result for the accepted beat
  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    pos_nxt     = pos_r;
    len_lo_nxt  = len_lo_r;
    hcrc_nxt    = hcrc_r;
    fcrc_nxt    = fcrc_r;
    tail_lo_nxt = tail_lo_r;
    q_wr.push             = 1'b0;
    q_wr.data.body_byte   = b;
    q_wr.data.body_index  = pos_r;
    q_wr.data.payload_len = len_lo_r[6:0];
    q_wr.data.is_last     = 1'b0;
    q_wr.data.frame_ok    = 1'b0;
    if (accept) begin
      case (phase_r)
        crcfr_pkg::PH_HUNT: begin
          if (b == start_byte_r) begin
            hcrc_nxt   = crcfr_pkg::crc8_step(hdr_init_r, b, hdr_poly_r);
            fcrc_nxt   = crcfr_pkg::crc16_step(frm_init_r, b, frm_poly_r);
            len_lo_nxt = 8'd0;
            rem_nxt    = '0;
            pos_nxt    = 7'd0;
            phase_nxt  = crcfr_pkg::PH_LEN_LO;
          end
        end
        crcfr_pkg::PH_LEN_LO: begin
          len_lo_nxt = b;
          hcrc_nxt   = hcrc_feed;
          fcrc_nxt   = fcrc_feed;
          phase_nxt  = crcfr_pkg::PH_LEN_HI;
        end
        crcfr_pkg::PH_LEN_HI: begin
          hcrc_nxt = hcrc_feed;
          fcrc_nxt = fcrc_feed;
          if (too_long) begin
            phase_nxt = crcfr_pkg::PH_HUNT;
            rem_nxt   = '0;
            pos_nxt   = 7'd0;
          end else begin
            rem_nxt   = total[crcfr_pkg::REM_W-1:0];
            phase_nxt = crcfr_pkg::PH_SEQ;
          end
        end
        crcfr_pkg::PH_SEQ: begin
          hcrc_nxt  = hcrc_feed;
          fcrc_nxt  = fcrc_feed;
          phase_nxt = crcfr_pkg::PH_HCRC;
        end
        crcfr_pkg::PH_HCRC: begin
          if (b == hcrc_r) begin
            fcrc_nxt  = fcrc_feed;
            pos_nxt   = 7'd0;
            phase_nxt = crcfr_pkg::PH_BODY;
          end else begin
            phase_nxt = crcfr_pkg::PH_HUNT;
            rem_nxt   = '0;
            pos_nxt   = 7'd0;
          end
        end
        crcfr_pkg::PH_BODY: begin
          if (rem_r == '0) begin
            phase_nxt = crcfr_pkg::PH_HUNT;
            pos_nxt   = 7'd0;
          end else begin
            // Payload bytes feed the CRC, tail bytes are compared against it
            if (rem_r > crcfr_pkg::REM_W'(2)) begin
              fcrc_nxt = fcrc_feed;
            end else if (rem_r == crcfr_pkg::REM_W'(2)) begin
              tail_lo_nxt = b;
            end else begin
              q_wr.data.is_last  = 1'b1;
              q_wr.data.frame_ok = (fcrc_r == {b, tail_lo_r});
            end
            q_wr.push = 1'b1;
            rem_nxt   = rem_r - crcfr_pkg::REM_W'(1);
            pos_nxt   = pos_r + 7'd1;
            if (rem_r == crcfr_pkg::REM_W'(1)) begin
              phase_nxt = crcfr_pkg::PH_HUNT;
              pos_nxt   = 7'd0;
            end
          end
        end
        default: begin
          phase_nxt = crcfr_pkg::PH_HUNT;
          rem_nxt   = '0;
          pos_nxt   = 7'd0;
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= crcfr_pkg::PH_HUNT;
      rem_r     <= '0;
      pos_r     <= 7'd0;
      len_lo_r  <= 8'd0;
      hcrc_r    <= crcfr_pkg::HDR_CRC_INIT_RST;
      fcrc_r    <= crcfr_pkg::FRM_CRC_INIT_RST;
      tail_lo_r <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      pos_r     <= pos_nxt;
      len_lo_r  <= len_lo_nxt;
      hcrc_r    <= hcrc_nxt;
      fcrc_r    <= fcrc_nxt;
      tail_lo_r <= tail_lo_nxt;
    end
  end

  // Configuration writes; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= crcfr_pkg::START_BYTE_RST;
      max_body_r   <= crcfr_pkg::MAX_BODY_RST;
      hdr_init_r   <= crcfr_pkg::HDR_CRC_INIT_RST;
      hdr_poly_r   <= crcfr_pkg::HDR_CRC_POLY_RST;
      frm_init_r   <= crcfr_pkg::FRM_CRC_INIT_RST;
      frm_poly_r   <= crcfr_pkg::FRM_CRC_POLY_RST;
    end else if (cfg_we) begin
      case (crcfr_pkg::cfg_idx_t'(cfg_index))
        crcfr_pkg::CFG_START_BYTE:   start_byte_r <= cfg_wdata[7:0];
        crcfr_pkg::CFG_MAX_BODY_LEN: max_body_r   <= cfg_wdata[6:0];
        crcfr_pkg::CFG_HDR_CRC_INIT: hdr_init_r   <= cfg_wdata[7:0];
        crcfr_pkg::CFG_HDR_CRC_POLY: hdr_poly_r   <= cfg_wdata[7:0];
        crcfr_pkg::CFG_FRM_CRC_INIT: frm_init_r   <= cfg_wdata;
        crcfr_pkg::CFG_FRM_CRC_POLY: frm_poly_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Results come only from body bytes, and the last one ends the frame
  a_push_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (phase_r == crcfr_pkg::PH_BODY))
    else $error("result pushed outside body phase");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && q_wr.data.is_last) |=> (phase_r == crcfr_pkg::PH_HUNT))
    else $error("parser did not return to hunting after last byte");

endmodule

// ----- src/crcfr_queue.sv -----
// Short result queue between the parser and the output stage.
module crcfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  crcfr_pkg::q_wr_t wr,
  input  logic             pop,
  output logic             full,
  output crcfr_pkg::q_rd_t rd
);

  crcfr_pkg::res_t               mem_r [crcfr_pkg::Q_DEPTH];
  logic [crcfr_pkg::Q_AW-1:0]    wp_r, rp_r;
  logic [crcfr_pkg::Q_CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == crcfr_pkg::Q_CW'(crcfr_pkg::Q_DEPTH));
  assign rd.empty = (cnt_r == '0);
  assign rd.data  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({wr.push, pop})
      2'b10:   cnt_nxt = cnt_r + crcfr_pkg::Q_CW'(1);
      2'b01:   cnt_nxt = cnt_r - crcfr_pkg::Q_CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr.push) wp_r <= wp_r + crcfr_pkg::Q_AW'(1);
      if (pop)     rp_r <= rp_r + crcfr_pkg::Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Store beats
  always_ff @(posedge clk) begin
    if (wr.push) mem_r[wp_r] <= wr.data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !rd.empty)
    else $error("pop from empty queue");

endmodule

// ----- src/crcfr_back.sv -----
// Output stage: takes results off the queue and holds them for the sink.
module crcfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  crcfr_pkg::q_rd_t rd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_body_byte,
  output logic [6:0]       out_body_index,
  output logic [6:0]       out_payload_len,
  output logic             out_is_last,
  output logic             out_frame_ok
);

  logic            out_valid_r, out_valid_nxt;
  crcfr_pkg::res_t out_data_r;

  // Load a new beat when the register is empty or being drained
  assign pop = !rd.empty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= rd.data;
  end

  assign out_valid       = out_valid_r;
  assign out_body_byte   = out_data_r.body_byte;
  assign out_body_index  = out_data_r.body_index;
  assign out_payload_len = out_data_r.payload_len;
  assign out_is_last     = out_data_r.is_last;
  assign out_frame_ok    = out_data_r.frame_ok;

endmodule

// ----- src/crc_checked_frame_receiver.sv -----
// Top level of the framed byte receiver with header CRC8 and frame CRC16 checks.
//
//  channel | direction | handshake            | beat contents
//  in_     | sink      | in_valid / in_ready   | rx_byte
//  out_    | source    | out_valid / out_ready | body_byte, body_index, payload_len,
//          |           |                       | is_last, frame_ok
//  cfg_    | sink      | cfg_we, no wait       | cfg_index, cfg_wdata
//
// One byte a cycle while in_ready is high: the parser does a byte-wide CRC8 and
// CRC16 update and its phase step for each accepted byte. A result is written to
// the queue when its byte is accepted, then moves to the output register.
// Reset is synchronous and loads the register defaults; there is no clearing pass.
// A four-beat queue and the output register absorb sink stalls; in_ready drops
// only when the queue is full.
module crc_checked_frame_receiver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_body_byte,
  output logic [6:0]                       out_body_index,
  output logic [6:0]                       out_payload_len,
  output logic                             out_is_last,
  output logic                             out_frame_ok,
  input  logic                             cfg_we,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  crcfr_pkg::q_wr_t q_wr;
  crcfr_pkg::q_rd_t q_rd;
  logic             q_full;
  logic             q_pop;

  crcfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  crcfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .rd    (q_rd)
  );

  crcfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd              (q_rd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_body_byte   (out_body_byte),
    .out_body_index  (out_body_index),
    .out_payload_len (out_payload_len),
    .out_is_last     (out_is_last),
    .out_frame_ok    (out_frame_ok)
  );

endmodule
